@@ design/ftcv_pkg.sv @@
// ----------------------------------------------------------------------------
// ftcv_pkg: shared types and constants of the file transfer CRC verifier
// Opcodes, result codes, the decoded command word and the CRC byte step.
// ----------------------------------------------------------------------------
package ftcv_pkg;

  // Largest frame on the link, header included, and the header size.
  localparam int MAX_FRAME    = 520;
  localparam int HEADER_BYTES = 4;

  // Longest payload that still fits in one frame.
  localparam logic [10:0] FRAME_LEN_LIMIT = 11'(MAX_FRAME - HEADER_BYTES);

  localparam logic [31:0] CRC_POLY            = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES            = 32'hFFFF_FFFF;
  localparam logic [31:0] PROGRESS_STEP_RESET = 32'd131072;

  // Input opcodes.
  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_HEADER = 3'd1;
  localparam logic [2:0] OP_BYTE   = 3'd2;
  localparam logic [2:0] OP_GAP    = 3'd3;
  localparam logic [2:0] OP_FINISH = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_GAP        = 3'd1;
  localparam logic [2:0] ST_SIZE       = 3'd2;
  localparam logic [2:0] ST_CHECKSUM   = 3'd3;
  localparam logic [2:0] ST_IDLE       = 3'd4;
  localparam logic [2:0] ST_FRAME_REJ  = 3'd5;
  localparam logic [2:0] ST_START_REJ  = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] REG_EXPECTED_SIZE = 2'd0;
  localparam logic [1:0] REG_EXPECTED_CRC  = 2'd1;
  localparam logic [1:0] REG_PROGRESS_STEP = 2'd2;

  // Decoded command kinds passed from the front to the back.
  typedef enum logic [2:0] {
    CMD_START,
    CMD_HEADER,
    CMD_BYTE,
    CMD_GAP,
    CMD_FINISH
  } cmd_kind_t;

  // One classified word waiting for execution.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] offset;
    logic [9:0]  length;
    logic [7:0]  data;
    logic        too_long;
  } cmd_t;

  // One result word waiting to be popped.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [31:0] received_bytes;
    logic [31:0] crc_value;
    logic        progress;
  } result_t;

  // Reflected CRC-32 update by one byte, eight bit steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ design/ftcv_front.sv @@
// ----------------------------------------------------------------------------
// ftcv_front: input side of the verifier
// Accepts words, decodes the opcode, checks frame length, and holds the
// classified commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ftcv_front
  import ftcv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [31:0] frame_offset,
  input  logic [9:0]  payload_length,
  input  logic [7:0]  data_byte,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t        q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        accept;
  logic        op_known;
  logic        q_write;
  cmd_t        decoded;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign accept    = push && !full;
  assign q_write   = accept && op_known;

  // Classify the incoming word; unknown opcodes are dropped here.
  always_comb begin
    op_known         = 1'b1;
    decoded.kind     = CMD_GAP;
    decoded.offset   = frame_offset;
    decoded.length   = payload_length;
    decoded.data     = data_byte;
    decoded.too_long = ({1'b0, payload_length} > FRAME_LEN_LIMIT);
    case (op)
      OP_START:  decoded.kind = CMD_START;
      OP_HEADER: decoded.kind = CMD_HEADER;
      OP_BYTE:   decoded.kind = CMD_BYTE;
      OP_GAP:    decoded.kind = CMD_GAP;
      OP_FINISH: decoded.kind = CMD_FINISH;
      default:   op_known = 1'b0;
    endcase
  end

  // Queue storage carries no reset.
  always_ff @(posedge clk) begin
    if (q_write) begin
      q[wr_ptr] <= decoded;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_write) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({q_write, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/ftcv_back.sv @@
// ----------------------------------------------------------------------------
// ftcv_back: execution side of the verifier
// Holds configuration and transfer state and queues results; with room in
// that queue, runs one command per cycle (CRC step, bookkeeping, verdict).
// ----------------------------------------------------------------------------
module ftcv_back
  import ftcv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic [31:0] received_bytes,
  output logic [31:0] crc_value,
  output logic        progress
);

  // Configuration registers.
  logic [31:0] expected_size;
  logic [31:0] expected_crc;
  logic [31:0] progress_step;

  // Transfer state.
  logic        active,          active_next;
  logic        gap_seen,        gap_seen_next;
  logic [31:0] received_count,  received_count_next;
  logic [31:0] crc_register,    crc_register_next;
  logic [31:0] next_mark,       next_mark_next;
  logic        in_frame,        in_frame_next;
  logic [31:0] current_offset,  current_offset_next;
  logic [9:0]  bytes_left,      bytes_left_next;
  logic        crc_enabled,     crc_enabled_next;

  // Result queue.
  result_t     rq [2];
  logic        rq_wr_ptr;
  logic        rq_rd_ptr;
  logic [1:0]  rq_count;
  logic        rq_room;
  logic        rq_write;
  logic        rq_read;

  logic        exec;
  logic        emit;
  logic [1:0]  res_kind;
  logic [2:0]  res_status;
  logic        res_progress;
  logic [31:0] offset_inc;
  logic        complete;
  logic [31:0] complete_count;
  result_t     res;

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size <= 32'd0;
      expected_crc  <= 32'd0;
      progress_step <= PROGRESS_STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXPECTED_SIZE: expected_size <= cfg_data;
        REG_EXPECTED_CRC:  expected_crc  <= cfg_data;
        REG_PROGRESS_STEP: progress_step <= cfg_data;
        default:           expected_size <= expected_size;
      endcase
    end
  end

  // A command runs only when the result queue has a free slot or is being popped.
  assign empty   = (rq_count == 2'd0);
  assign rq_read = pop && !empty;
  assign rq_room = (rq_count != 2'd2) || rq_read;
  assign exec    = cmd_valid && rq_room;
  assign cmd_pop = exec;

  assign offset_inc = current_offset + 32'd1;

  // Command execution: next state and the result word.
  always_comb begin
    active_next         = active;
    gap_seen_next       = gap_seen;
    received_count_next = received_count;
    crc_register_next   = crc_register;
    next_mark_next      = next_mark;
    in_frame_next       = in_frame;
    current_offset_next = current_offset;
    bytes_left_next     = bytes_left;
    crc_enabled_next    = crc_enabled;
    emit                = 1'b0;
    res_kind            = KIND_START;
    res_status          = ST_OK;
    complete            = 1'b0;
    complete_count      = current_offset;
    case (cmd.kind)
      CMD_START: begin
        active_next     = 1'b0;
        in_frame_next   = 1'b0;
        bytes_left_next = 10'd0;
        emit            = 1'b1;
        res_kind        = KIND_START;
        if (expected_size == 32'd0) begin
          res_status = ST_START_REJ;
        end else begin
          received_count_next = 32'd0;
          crc_register_next   = ALL_ONES;
          next_mark_next      = progress_step;
          gap_seen_next       = 1'b0;
          active_next         = 1'b1;
        end
      end
      CMD_HEADER: begin
        in_frame_next   = 1'b0;
        bytes_left_next = 10'd0;
        if (!active) begin
          emit       = 1'b1;
          res_kind   = KIND_FRAME;
          res_status = ST_IDLE;
        end else if (cmd.too_long) begin
          emit       = 1'b1;
          res_kind   = KIND_FRAME;
          res_status = ST_FRAME_REJ;
        end else begin
          if (cmd.offset > received_count) begin
            gap_seen_next = 1'b1;
          end
          crc_enabled_next    = (cmd.offset == received_count);
          current_offset_next = cmd.offset;
          bytes_left_next     = cmd.length;
          in_frame_next       = 1'b1;
          // An empty frame completes at its header.
          if (cmd.length == 10'd0) begin
            complete       = 1'b1;
            complete_count = cmd.offset;
          end
        end
      end
      CMD_BYTE: begin
        if (in_frame && (bytes_left != 10'd0)) begin
          if (crc_enabled) begin
            crc_register_next = crc_byte(crc_register, cmd.data);
          end
          current_offset_next = offset_inc;
          bytes_left_next     = bytes_left - 10'd1;
          if (bytes_left == 10'd1) begin
            complete       = 1'b1;
            complete_count = offset_inc;
          end
        end
      end
      CMD_GAP: begin
        gap_seen_next = 1'b1;
      end
      CMD_FINISH: begin
        emit     = 1'b1;
        res_kind = KIND_FINISH;
        if (!active) begin
          res_status = ST_IDLE;
        end else begin
          in_frame_next   = 1'b0;
          bytes_left_next = 10'd0;
          active_next     = 1'b0;
          if (gap_seen) begin
            res_status = ST_GAP;
          end else if (received_count != expected_size) begin
            res_status = ST_SIZE;
          end else if (~crc_register != expected_crc) begin
            res_status = ST_CHECKSUM;
          end else begin
            res_status = ST_OK;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    // Frame completion: commit the count and check the progress mark.
    res_progress = 1'b0;
    if (complete) begin
      received_count_next = complete_count;
      in_frame_next       = 1'b0;
      bytes_left_next     = 10'd0;
      emit                = 1'b1;
      res_kind            = KIND_FRAME;
      res_status          = ST_OK;
      if (active && (complete_count >= next_mark)) begin
        next_mark_next = next_mark + progress_step;
        res_progress   = 1'b1;
      end
    end
  end

  assign res.kind           = res_kind;
  assign res.status         = res_status;
  assign res.received_bytes = received_count_next;
  assign res.crc_value      = ~crc_register_next;
  assign res.progress       = res_progress;
  assign rq_write           = exec && emit;

  // Transfer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      gap_seen       <= 1'b0;
      received_count <= 32'd0;
      crc_register   <= ALL_ONES;
      next_mark      <= 32'd0;
      in_frame       <= 1'b0;
      current_offset <= 32'd0;
      bytes_left     <= 10'd0;
      crc_enabled    <= 1'b0;
    end else if (exec) begin
      active         <= active_next;
      gap_seen       <= gap_seen_next;
      received_count <= received_count_next;
      crc_register   <= crc_register_next;
      next_mark      <= next_mark_next;
      in_frame       <= in_frame_next;
      current_offset <= current_offset_next;
      bytes_left     <= bytes_left_next;
      crc_enabled    <= crc_enabled_next;
    end
  end

  // Result queue storage carries no reset.
  always_ff @(posedge clk) begin
    if (rq_write) begin
      rq[rq_wr_ptr] <= res;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr_ptr <= 1'b0;
      rq_rd_ptr <= 1'b0;
      rq_count  <= 2'd0;
    end else begin
      if (rq_write) begin
        rq_wr_ptr <= ~rq_wr_ptr;
      end
      if (rq_read) begin
        rq_rd_ptr <= ~rq_rd_ptr;
      end
      case ({rq_write, rq_read})
        2'b10:   rq_count <= rq_count + 2'd1;
        2'b01:   rq_count <= rq_count - 2'd1;
        default: rq_count <= rq_count;
      endcase
    end
  end

  // Oldest waiting result on the output ports.
  assign kind           = rq[rq_rd_ptr].kind;
  assign status         = rq[rq_rd_ptr].status;
  assign received_bytes = rq[rq_rd_ptr].received_bytes;
  assign crc_value      = rq[rq_rd_ptr].crc_value;
  assign progress       = rq[rq_rd_ptr].progress;

endmodule

@@ design/file_transfer_crc_verifier_top.sv @@
// ----------------------------------------------------------------------------
// file_transfer_crc_verifier_top: CRC-32 checker for framed file transfers
// Usage:
//   Input words enter through push/full with op, frame_offset,
//   payload_length and data_byte; a word is taken when push is high and
//   full is low. Results leave through empty/pop: the oldest result sits
//   on kind, status, received_bytes, crc_value and progress while empty is
//   low, and is taken when pop is high. Registers (expected size, expected
//   CRC, progress step) are written through cfg_valid/cfg_ready with
//   cfg_index and cfg_data; cfg_ready is always high, and writes belong
//   only in quiet periods between transfers.
//   One word is taken every cycle while full is low. A word that gives a
//   result is first registered in the command queue, where the execution
//   unit runs its CRC byte step and state update on it; its result is then
//   written to the result queue and shows on the output ports from there.
//   When the receiver stalls, the two-entry result queue fills, execution
//   holds, the two-entry command queue fills and full rises; nothing is lost.
//   Synchronous reset empties both queues, closes any transfer and loads
//   the register defaults (progress step 131072).
// ----------------------------------------------------------------------------
module file_transfer_crc_verifier_top
  import ftcv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [31:0] frame_offset,
  input  logic [9:0]  payload_length,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic [31:0] received_bytes,
  output logic [31:0] crc_value,
  output logic        progress,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Front end: accept and classify words.
  ftcv_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .op             (op),
    .frame_offset   (frame_offset),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Back end: run commands and queue results.
  ftcv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .kind           (kind),
    .status         (status),
    .received_bytes (received_bytes),
    .crc_value      (crc_value),
    .progress       (progress)
  );

endmodule
